// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is low
`define ATRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// signal holds its value in the cycle after the condition
`define ATRP_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/core/atrp_pkg.sv =====
// types, widths and constants of the accelerometer tilt block
`timescale 1ns / 1ps

package atrp_pkg;

  // field widths
  localparam int unsigned AXW      = 16;
  localparam int unsigned ROLL_W   = 17;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned OFF_W    = 13;
  localparam int unsigned DB_W     = 12;

  // configuration port
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  // square root datapath
  localparam int unsigned SQ_W     = 2 * AXW - 1;      // one square
  localparam int unsigned SUM_W    = 2 * AXW;          // y^2 + z^2
  localparam int unsigned OPER_SHIFT = 14;             // operands scaled by 2^14
  localparam int unsigned ROOT_W   = (SUM_W + 2 * OPER_SHIFT) / 2;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned SQ_CELLS = ROOT_W;           // one root bit per cell

  // cordic datapath
  localparam int unsigned CW       = 34;               // vector components
  localparam int unsigned AW       = 26;               // angle, Q16 degrees
  localparam int unsigned ATAN_W   = 23;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned Q8_W     = AW - 8;
  localparam int unsigned ANG_W    = Q8_W + 1;

  localparam logic signed [AW-1:0]    DEG180_Q16   = AW'(180 * 65536);
  localparam logic signed [AW-1:0]    HALF_Q8      = AW'(128);
  localparam logic signed [ANG_W-1:0] ROLL_WRAP_Q8 = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] FULL_TURN_Q8 = ANG_W'(92160);

  // register reset values
  localparam logic [OFF_W-1:0] ROLL_OFF_RST  = OFF_W'(845);
  localparam logic [OFF_W-1:0] PITCH_OFF_RST = OFF_W'(0);
  localparam logic [DB_W-1:0]  DEADBAND_RST  = DB_W'(512);

  typedef enum logic [1:0] {
    REG_ROLL_BIAS  = 2'd0,
    REG_PITCH_BIAS = 2'd1,
    REG_DEADBAND   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [AXW-1:0] accel_x;
    logic signed [AXW-1:0] accel_y;
    logic signed [AXW-1:0] accel_z;
  } accel_in_t;

  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
  } tilt_out_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] roll_bias;
    logic signed [OFF_W-1:0] pitch_bias;
    logic [DB_W-1:0]         deadband;
  } cfg_t;

  typedef struct packed {
    accel_in_t         accel;
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                 hold;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
  } cordic_t;

  typedef struct packed {
    logic signed [AW-1:0] roll_acc;
    logic signed [AW-1:0] pitch_acc;
  } ang_t;

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:       v = ATAN_W'(2949120);
      1:       v = ATAN_W'(1740967);
      2:       v = ATAN_W'(919879);
      3:       v = ATAN_W'(466945);
      4:       v = ATAN_W'(234379);
      5:       v = ATAN_W'(117304);
      6:       v = ATAN_W'(58666);
      7:       v = ATAN_W'(29335);
      8:       v = ATAN_W'(14668);
      9:       v = ATAN_W'(7334);
      10:      v = ATAN_W'(3667);
      11:      v = ATAN_W'(1833);
      12:      v = ATAN_W'(917);
      13:      v = ATAN_W'(458);
      14:      v = ATAN_W'(229);
      15:      v = ATAN_W'(115);
      16:      v = ATAN_W'(57);
      17:      v = ATAN_W'(29);
      18:      v = ATAN_W'(14);
      19:      v = ATAN_W'(7);
      20:      v = ATAN_W'(4);
      21:      v = ATAN_W'(2);
      22:      v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/atrp_sqrt_cell.sv =====
// one cell of the square root chain: one root bit per cell
`timescale 1ns / 1ps

module atrp_sqrt_cell import atrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  cell_i,
  output logic valid_o,
  output sq_t  cell_o
);

  logic             valid_q;
  sq_t              cell_q, cell_d;
  logic [REM_W+1:0] cur, trial, diff;
  logic             ge;

  always_comb begin
    cur   = {cell_i.rem, cell_i.rad[SUM_W-1 -: 2]};
    trial = (REM_W + 2)'({cell_i.root, 2'b01});
    diff  = cur - trial;
    ge    = (cur >= trial);
    cell_d       = cell_i;
    cell_d.rad   = {cell_i.rad[SUM_W-3:0], 2'b00};
    cell_d.rem   = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    cell_d.root  = {cell_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== rtl/core/atrp_cordic_cell.sv =====
// one vectoring cordic iteration, applied to the roll and the pitch vector
`timescale 1ns / 1ps

module atrp_cordic_cell import atrp_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t cell_i,
  output logic    valid_o,
  output cordic_t cell_o
);

  localparam logic signed [AW-1:0] AtanStep = AW'(atan_q16(Idx));

  logic    valid_q;
  cordic_t cell_q, cell_d;

  function automatic rot_t rotate(input rot_t v);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    rot_t                 r;
    dx = $signed(v.x) >>> Idx;
    dy = $signed(v.y) >>> Idx;
    r  = v;
    if (!v.hold) begin
      if ($signed(v.y) >= 0) begin
        r.x   = $signed(v.x) + dy;
        r.y   = $signed(v.y) - dx;
        r.acc = $signed(v.acc) + AtanStep;
      end else begin
        r.x   = $signed(v.x) - dy;
        r.y   = $signed(v.y) + dx;
        r.acc = $signed(v.acc) - AtanStep;
      end
    end
    return r;
  endfunction

  always_comb begin
    cell_d.roll  = rotate(cell_i.roll);
    cell_d.pitch = rotate(cell_i.pitch);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== rtl/core/atrp_post.sv =====
// rounding to q8, offsets, roll wrap and deadband over four stages
`timescale 1ns / 1ps

module atrp_post import atrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  ang_t      ang_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output tilt_out_t data_o
);

  logic [3:0] v_q;

  logic signed [AW-1:0]    roll_rnd, pitch_rnd;
  logic signed [Q8_W-1:0]  a_roll_q, a_pitch_q;
  logic signed [ANG_W-1:0] b_roll_d, b_pitch_d, b_roll_q, b_pitch_q;
  logic signed [ANG_W-1:0] c_roll_d, c_roll_q, c_pitch_q;
  tilt_out_t               d_data_d, d_data_q;

  function automatic logic below_db(input logic signed [ANG_W-1:0] v,
                                    input logic [DB_W-1:0] db);
    logic [ANG_W-1:0] mag;
    mag = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
    return (mag < ANG_W'(db));
  endfunction

  always_comb begin
    roll_rnd  = ang_i.roll_acc + HALF_Q8;
    pitch_rnd = ang_i.pitch_acc + HALF_Q8;

    b_roll_d  = ANG_W'(a_roll_q) + ANG_W'($signed(cfg_i.roll_bias));
    b_pitch_d = ANG_W'(a_pitch_q) + ANG_W'($signed(cfg_i.pitch_bias));

    // roll above half a turn goes to the negative side
    c_roll_d = (b_roll_q > ROLL_WRAP_Q8) ? (b_roll_q - FULL_TURN_Q8) : b_roll_q;

    d_data_d.roll_angle  = below_db(c_roll_q, cfg_i.deadband) ? '0
                                                               : c_roll_q[ROLL_W-1:0];
    d_data_d.pitch_angle = below_db(c_pitch_q, cfg_i.deadband) ? '0
                                                                : c_pitch_q[PITCH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_roll_q  <= roll_rnd[AW-1:8];
      a_pitch_q <= pitch_rnd[AW-1:8];
      b_roll_q  <= b_roll_d;
      b_pitch_q <= b_pitch_d;
      c_roll_q  <= c_roll_d;
      c_pitch_q <= b_pitch_q;
      d_data_q  <= d_data_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = d_data_q;

endmodule

// ===== rtl/core/accel_tilt_roll_pitch.sv =====
// top level: roll and pitch angles from one accelerometer triple
`timescale 1ns / 1ps

// Takes one signed accelerometer triple (x, y, z) per item and returns roll and
// pitch in signed Q8 degrees. roll = roll bias + atan2(y, z), wrapped by -360
// above +180; pitch = pitch bias + atan2(-x, sqrt(y^2 + z^2)); either angle
// whose magnitude is below deadband comes out as zero. The block is a pipeline
// that takes a new item in every cycle while in_stall_o is low: two
// multiply/add stages for y^2 + z^2, a chain of 30 square root cells (one root
// bit each), one quadrant fold stage, a chain of CORDIC_STAGES cordic cells,
// capped at ATAN_LEN, that rotate the roll and the pitch vector side by side,
// four stages of rounding, offset, wrap and deadband, and an output register
// with one skid entry. in_stall_o rises only when the output register and the
// skid entry are both full; the whole pipeline then holds until the output
// item is taken. Registers sit on an APB-style port: roll bias at 0x0, pitch
// bias at 0x4, deadband at 0x8. They are meant to be written while the block
// is empty.

module accel_tilt_roll_pitch import atrp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  accel_in_t          in_data_i,
  // item output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tilt_out_t          out_data_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned NumStg = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  // pipeline advance: everything moves unless the skid entry is occupied
  logic pipe_en;

  // configuration registers
  cfg_t cfg_q;
  logic cfg_wr;

  // squares and their sum
  logic signed [2*AXW-1:0] ysq_full, zsq_full;
  logic                    p1_v_q, p2_v_q;
  accel_in_t               p1_accel_q, p2_accel_q;
  logic [SQ_W-1:0]         ysq_q, zsq_q;
  logic [SUM_W-1:0]        sum_q;

  // square root chain
  logic sq_v [SQ_CELLS+1];
  sq_t  sq_d [SQ_CELLS+1];

  // quadrant fold and cordic chain
  logic                 pr_v_q;
  cordic_t              pr_d, pr_q;
  logic signed [CW-1:0] roll_y, roll_x, pitch_y, pitch_x, ax_ext;
  logic                 cd_v [NumStg+1];
  cordic_t              cd_d [NumStg+1];
  ang_t                 ang;

  // post stages
  logic      post_v;
  tilt_out_t post_data;

  // output register and skid entry
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  tilt_out_t out_data_q, skid_data_q;
  logic      pop, push, load_out, load_skid, out_from_skid;

  assign pipe_en = !skid_valid_q;

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_bias  <= ROLL_OFF_RST;
      cfg_q.pitch_bias <= PITCH_OFF_RST;
      cfg_q.deadband   <= DEADBAND_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[PADDR_W-1:2]))
        REG_ROLL_BIAS:  cfg_q.roll_bias  <= pwdata[OFF_W-1:0];
        REG_PITCH_BIAS: cfg_q.pitch_bias <= pwdata[OFF_W-1:0];
        REG_DEADBAND:   cfg_q.deadband   <= pwdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets read back sign extended
  always_comb begin
    case (cfg_reg_e'(paddr[PADDR_W-1:2]))
      REG_ROLL_BIAS:  prdata = PDATA_W'($signed(cfg_q.roll_bias));
      REG_PITCH_BIAS: prdata = PDATA_W'($signed(cfg_q.pitch_bias));
      REG_DEADBAND:   prdata = PDATA_W'(cfg_q.deadband);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // y^2 and z^2, then their sum
  // ---------------------------------------------------------------------------
  assign ysq_full = $signed(in_data_i.accel_y) * $signed(in_data_i.accel_y);
  assign zsq_full = $signed(in_data_i.accel_z) * $signed(in_data_i.accel_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (pipe_en) begin
      p1_v_q <= in_valid_i;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_accel_q <= in_data_i;
      ysq_q      <= ysq_full[SQ_W-1:0];
      zsq_q      <= zsq_full[SQ_W-1:0];
      p2_accel_q <= p1_accel_q;
      sum_q      <= SUM_W'(ysq_q) + SUM_W'(zsq_q);
    end
  end

  // ---------------------------------------------------------------------------
  // square root of sum * 2^28: radius scaled like the other cordic operands
  // ---------------------------------------------------------------------------
  assign sq_v[0]       = p2_v_q;
  assign sq_d[0].accel = p2_accel_q;
  assign sq_d[0].rad   = sum_q;
  assign sq_d[0].rem   = '0;
  assign sq_d[0].root  = '0;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    atrp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (sq_v[k]),
      .cell_i  (sq_d[k]),
      .valid_o (sq_v[k+1]),
      .cell_o  (sq_d[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // quadrant fold: a negative second operand turns the vector by 180 degrees,
  // a zero first operand is already exact and skips every iteration
  // ---------------------------------------------------------------------------
  function automatic rot_t fold(input logic signed [CW-1:0] y,
                                input logic signed [CW-1:0] x);
    rot_t r;
    r.hold = (y == '0);
    if (x < 0) begin
      r.x   = -x;
      r.y   = -y;
      r.acc = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
    end else begin
      r.x   = x;
      r.y   = y;
      r.acc = '0;
    end
    return r;
  endfunction

  always_comb begin
    roll_y  = {{(CW-AXW-OPER_SHIFT){sq_d[SQ_CELLS].accel.accel_y[AXW-1]}},
               sq_d[SQ_CELLS].accel.accel_y, {OPER_SHIFT{1'b0}}};
    roll_x  = {{(CW-AXW-OPER_SHIFT){sq_d[SQ_CELLS].accel.accel_z[AXW-1]}},
               sq_d[SQ_CELLS].accel.accel_z, {OPER_SHIFT{1'b0}}};
    ax_ext  = {{(CW-AXW-OPER_SHIFT){sq_d[SQ_CELLS].accel.accel_x[AXW-1]}},
               sq_d[SQ_CELLS].accel.accel_x, {OPER_SHIFT{1'b0}}};
    pitch_y = -ax_ext;
    pitch_x = CW'(sq_d[SQ_CELLS].root);
    pr_d.roll  = fold(roll_y, roll_x);
    pr_d.pitch = fold(pitch_y, pitch_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (pipe_en) begin
      pr_v_q <= sq_v[SQ_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pr_q <= pr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // cordic chain, one iteration per cell
  // ---------------------------------------------------------------------------
  assign cd_v[0] = pr_v_q;
  assign cd_d[0] = pr_q;

  for (genvar k = 0; k < NumStg; k++) begin : g_cordic
    atrp_cordic_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (cd_v[k]),
      .cell_i  (cd_d[k]),
      .valid_o (cd_v[k+1]),
      .cell_o  (cd_d[k+1])
    );
  end

  assign ang.roll_acc  = cd_d[NumStg].roll.acc;
  assign ang.pitch_acc = cd_d[NumStg].pitch.acc;

  atrp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (cd_v[NumStg]),
    .ang_i   (ang),
    .cfg_i   (cfg_q),
    .valid_o (post_v),
    .data_o  (post_data)
  );

  // ---------------------------------------------------------------------------
  // output register with one skid entry; the skid entry fills when an item
  // leaves the pipeline while the output item is held
  // ---------------------------------------------------------------------------
  assign pop  = out_valid_q && !out_stall_i;
  assign push = post_v && pipe_en;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_data_q <= skid_data_q;
    end else if (load_out) begin
      out_data_q <= post_data;
    end
    if (load_skid) begin
      skid_data_q <= post_data;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/atrp_checker.sv =====
// port level checks of the tilt block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atrp_checker import atrp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tilt_out_t out_data_o
);

  `ATRP_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output item dropped while stalled")
  `ATRP_ASSERT_STABLE(a_out_data_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_data_o, "output item changed while stalled")
  `ATRP_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && $past(out_valid_o && out_stall_i), "input stalled without a held output item")
  `ATRP_ASSERT(a_stall_release, clk_i, rst_ni, $fell(in_stall_o) |-> $past(out_valid_o && !out_stall_i), "input stall released without an output item taken")

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);
